/* hdl/dlc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dlc_pkg;

  localparam int MAX_NODES = 16;
  localparam int MAX_EDGES = 32;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int EIDX_W    = $clog2(MAX_EDGES);
  localparam int NCNT_W    = $clog2(MAX_NODES + 1);
  localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
  localparam int LAT_W     = 20;
  localparam int VAL_W     = 24;
  localparam int KIND_W    = 3;

  typedef enum logic [1:0] {
    ACT_NODE = 2'd0,
    ACT_EDGE = 2'd1,
    ACT_COMP = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    K_NODE   = 3'd0,
    K_EDGE   = 3'd1,
    K_DELAY  = 3'd2,
    K_DOMAIN = 3'd3,
    K_OVER   = 3'd4,
    K_ERROR  = 3'd5
  } kind_e;

  localparam logic [VAL_W-1:0] ERR_UNKNOWN    = 24'd0;
  localparam logic [VAL_W-1:0] ERR_NODES_FULL = 24'd1;
  localparam logic [VAL_W-1:0] ERR_EDGES_FULL = 24'd2;

  typedef enum logic [3:0] {
    EM_NODE,
    EM_ERR_UNKNOWN,
    EM_ERR_NODES,
    EM_ERR_EDGES,
    EM_EDGE_REJ,
    EM_EDGE_ACC,
    EM_DELAY,
    EM_DOMAIN,
    EM_OVER
  } emit_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MARK,
    ST_EDGE_DEC,
    ST_ARR_NODE,
    ST_ARR_EDGE,
    ST_ARR_WR,
    ST_OUT_NODE,
    ST_OUT_MAX,
    ST_OUT_DLY,
    ST_OUT_TAIL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic      ld_in;
    logic      emit;
    emit_sel_e sel;
    logic      node_wr;
    logic      edge_wr;
    logic      mark_init;
    logic      mark_step;
    logic      arr_clr;
    logic      arr_wr;
    logic      best_clr;
    logic      best_acc;
    logic      e_clr;
    logic      e_inc;
    logic      v_clr;
    logic      v_inc;
    logic      pass_clr;
    logic      pass_inc;
    logic      flush;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    from_bad;
    logic    to_bad;
    logic    self_loop;
    logic    nodes_full;
    logic    edges_full;
    logic    edges_none;
    logic    e_last;
    logic    v_last;
    logic    mark_pass_last;
    logic    arr_pass_last;
    logic    mark_v;
    logic    mark_to;
    logic    dly_hit;
    logic    is_target;
    logic    cap_exceeded;
    logic    emit_ok;
    logic    pend_v;
  } sts_t;

  typedef struct packed {
    logic                last;
    logic [VAL_W-1:0]    value;
    logic [NODE_W-1:0]   node_b;
    logic [NODE_W-1:0]   node_a;
    logic [KIND_W-1:0]   kind;
  } res_t;

endpackage

`default_nettype wire

/* hdl/dlc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dlc_pkg::sts_t sts_i,
  output dlc_pkg::cmd_t      cmd_o
);

  dlc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // leaving the mark sweep / arrival sweep
  logic mark_done, arr_done, tail_need;
  assign mark_done = sts_i.edges_none || (sts_i.e_last && sts_i.mark_pass_last);
  assign arr_done  = sts_i.v_last && sts_i.arr_pass_last;
  assign tail_need = sts_i.is_target || sts_i.cap_exceeded;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dlc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dlc_pkg::ST_DECODE;
      end
      dlc_pkg::ST_DECODE: begin
        case (sts_i.action)
          dlc_pkg::ACT_NODE: begin
            if (sts_i.emit_ok) state_d = dlc_pkg::ST_FLUSH;
          end
          dlc_pkg::ACT_EDGE: begin
            if (sts_i.from_bad || sts_i.to_bad || sts_i.self_loop) begin
              if (sts_i.emit_ok) state_d = dlc_pkg::ST_FLUSH;
            end else begin
              state_d = dlc_pkg::ST_MARK;
            end
          end
          dlc_pkg::ACT_COMP: begin
            if (sts_i.from_bad) begin
              if (sts_i.emit_ok) state_d = dlc_pkg::ST_FLUSH;
            end else begin
              state_d = dlc_pkg::ST_MARK;
            end
          end
          default: state_d = dlc_pkg::ST_IDLE;
        endcase
      end
      dlc_pkg::ST_MARK: begin
        if (mark_done) begin
          state_d = (sts_i.action == dlc_pkg::ACT_EDGE) ? dlc_pkg::ST_EDGE_DEC
                                                        : dlc_pkg::ST_ARR_NODE;
        end
      end
      dlc_pkg::ST_EDGE_DEC: begin
        if (sts_i.emit_ok) state_d = dlc_pkg::ST_FLUSH;
      end
      dlc_pkg::ST_ARR_NODE: begin
        if (sts_i.mark_v) begin
          state_d = sts_i.edges_none ? dlc_pkg::ST_ARR_WR : dlc_pkg::ST_ARR_EDGE;
        end else if (arr_done) begin
          state_d = dlc_pkg::ST_OUT_NODE;
        end
      end
      dlc_pkg::ST_ARR_EDGE: begin
        if (sts_i.e_last) state_d = dlc_pkg::ST_ARR_WR;
      end
      dlc_pkg::ST_ARR_WR: begin
        state_d = arr_done ? dlc_pkg::ST_OUT_NODE : dlc_pkg::ST_ARR_NODE;
      end
      dlc_pkg::ST_OUT_NODE: begin
        if (sts_i.mark_v) begin
          state_d = sts_i.edges_none ? dlc_pkg::ST_OUT_TAIL : dlc_pkg::ST_OUT_MAX;
        end else if (sts_i.v_last) begin
          state_d = dlc_pkg::ST_FLUSH;
        end
      end
      dlc_pkg::ST_OUT_MAX: begin
        if (sts_i.e_last) state_d = dlc_pkg::ST_OUT_DLY;
      end
      dlc_pkg::ST_OUT_DLY: begin
        if ((!sts_i.dly_hit || sts_i.emit_ok) && sts_i.e_last) begin
          state_d = dlc_pkg::ST_OUT_TAIL;
        end
      end
      dlc_pkg::ST_OUT_TAIL: begin
        if (!tail_need || sts_i.emit_ok) begin
          state_d = sts_i.v_last ? dlc_pkg::ST_FLUSH : dlc_pkg::ST_OUT_NODE;
        end
      end
      dlc_pkg::ST_FLUSH: begin
        if (!sts_i.pend_v) state_d = dlc_pkg::ST_IDLE;
      end
      default: state_d = dlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = dlc_pkg::EM_NODE;
    in_ready_o = 1'b0;
    case (state_q)
      dlc_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.ld_in = in_valid_i;
      end
      dlc_pkg::ST_DECODE: begin
        case (sts_i.action)
          dlc_pkg::ACT_NODE: begin
            cmd_o.emit    = sts_i.emit_ok;
            cmd_o.sel     = sts_i.nodes_full ? dlc_pkg::EM_ERR_NODES : dlc_pkg::EM_NODE;
            cmd_o.node_wr = sts_i.emit_ok && !sts_i.nodes_full;
          end
          dlc_pkg::ACT_EDGE: begin
            if (sts_i.from_bad || sts_i.to_bad) begin
              cmd_o.emit = sts_i.emit_ok;
              cmd_o.sel  = dlc_pkg::EM_ERR_UNKNOWN;
            end else if (sts_i.self_loop) begin
              cmd_o.emit = sts_i.emit_ok;
              cmd_o.sel  = dlc_pkg::EM_EDGE_REJ;
            end else begin
              cmd_o.mark_init = 1'b1;
              cmd_o.e_clr     = 1'b1;
              cmd_o.pass_clr  = 1'b1;
            end
          end
          dlc_pkg::ACT_COMP: begin
            if (sts_i.from_bad) begin
              cmd_o.emit = sts_i.emit_ok;
              cmd_o.sel  = dlc_pkg::EM_ERR_UNKNOWN;
            end else begin
              cmd_o.mark_init = 1'b1;
              cmd_o.e_clr     = 1'b1;
              cmd_o.pass_clr  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      dlc_pkg::ST_MARK: begin
        if (!sts_i.edges_none) begin
          cmd_o.mark_step = 1'b1;
          cmd_o.e_inc     = 1'b1;
          cmd_o.pass_inc  = sts_i.e_last;
        end
        if (mark_done) begin
          cmd_o.arr_clr  = 1'b1;
          cmd_o.v_clr    = 1'b1;
          cmd_o.pass_clr = 1'b1;
        end
      end
      dlc_pkg::ST_EDGE_DEC: begin
        cmd_o.emit = sts_i.emit_ok;
        if (sts_i.mark_to) begin
          cmd_o.sel = dlc_pkg::EM_EDGE_REJ;
        end else if (sts_i.edges_full) begin
          cmd_o.sel = dlc_pkg::EM_ERR_EDGES;
        end else begin
          cmd_o.sel     = dlc_pkg::EM_EDGE_ACC;
          cmd_o.edge_wr = sts_i.emit_ok;
        end
      end
      dlc_pkg::ST_ARR_NODE: begin
        if (sts_i.mark_v) begin
          cmd_o.best_clr = 1'b1;
          cmd_o.e_clr    = 1'b1;
        end else begin
          cmd_o.v_inc    = 1'b1;
          cmd_o.pass_inc = sts_i.v_last;
        end
      end
      dlc_pkg::ST_ARR_EDGE: begin
        cmd_o.best_acc = 1'b1;
        cmd_o.e_inc    = 1'b1;
      end
      dlc_pkg::ST_ARR_WR: begin
        cmd_o.arr_wr   = 1'b1;
        cmd_o.v_inc    = 1'b1;
        cmd_o.pass_inc = sts_i.v_last;
      end
      dlc_pkg::ST_OUT_NODE: begin
        if (sts_i.mark_v) begin
          cmd_o.best_clr = 1'b1;
          cmd_o.e_clr    = 1'b1;
        end else begin
          cmd_o.v_inc = 1'b1;
        end
      end
      dlc_pkg::ST_OUT_MAX: begin
        cmd_o.best_acc = 1'b1;
        cmd_o.e_inc    = 1'b1;
      end
      dlc_pkg::ST_OUT_DLY: begin
        cmd_o.sel = dlc_pkg::EM_DELAY;
        if (sts_i.dly_hit) begin
          cmd_o.emit  = sts_i.emit_ok;
          cmd_o.e_inc = sts_i.emit_ok;
        end else begin
          cmd_o.e_inc = 1'b1;
        end
      end
      dlc_pkg::ST_OUT_TAIL: begin
        cmd_o.sel = sts_i.is_target ? dlc_pkg::EM_DOMAIN : dlc_pkg::EM_OVER;
        if (!tail_need || sts_i.emit_ok) begin
          cmd_o.emit  = tail_need;
          cmd_o.v_inc = 1'b1;
        end
      end
      dlc_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/dlc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlc_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dlc_pkg::cmd_t                cmd_i,
  output dlc_pkg::sts_t                     sts_o,
  input  wire logic [1:0]                   action_i,
  input  wire logic [dlc_pkg::NODE_W-1:0]   from_node_i,
  input  wire logic [dlc_pkg::NODE_W-1:0]   to_node_i,
  input  wire logic [dlc_pkg::LAT_W-1:0]    latency_i,
  input  wire logic [dlc_pkg::VAL_W-1:0]    cap_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output dlc_pkg::res_t                     res_o
);

  // latched item
  dlc_pkg::action_e                action_q;
  logic [dlc_pkg::NODE_W-1:0]      from_q, to_q;
  logic [dlc_pkg::LAT_W-1:0]       lat_in_q;
  logic [dlc_pkg::VAL_W-1:0]       cap_q;

  // graph tables
  logic [dlc_pkg::NCNT_W-1:0]      nc_q;
  logic [dlc_pkg::ECNT_W-1:0]      ec_q;
  logic [dlc_pkg::LAT_W-1:0]       lat_q [dlc_pkg::MAX_NODES];
  logic [dlc_pkg::NODE_W-1:0]      src_q [dlc_pkg::MAX_EDGES];
  logic [dlc_pkg::NODE_W-1:0]      dst_q [dlc_pkg::MAX_EDGES];
  logic [dlc_pkg::VAL_W-1:0]       arr_q [dlc_pkg::MAX_NODES];
  logic [dlc_pkg::MAX_NODES-1:0]   mark_q;

  // walk counters
  logic [dlc_pkg::EIDX_W-1:0]      e_q;
  logic [dlc_pkg::NODE_W-1:0]      v_q;
  logic [dlc_pkg::NCNT_W-1:0]      pass_q;
  logic [dlc_pkg::VAL_W-1:0]       best_q;

  // pending result and output register
  logic                            pend_v_q, pend_v_d;
  dlc_pkg::res_t                   pend_q;
  logic                            out_v_q, out_v_d;
  dlc_pkg::res_t                   out_q;

  logic [dlc_pkg::NODE_W-1:0]      src_e, dst_e;
  logic [dlc_pkg::VAL_W-1:0]       arr_src;
  logic [dlc_pkg::LAT_W-1:0]       lat_v;
  logic [dlc_pkg::VAL_W:0]         sum;
  logic [dlc_pkg::VAL_W-1:0]       sat_sum;
  logic                            hit, out_free, e_last, v_last;
  dlc_pkg::res_t                   new_res;

  assign src_e   = src_q[e_q];
  assign dst_e   = dst_q[e_q];
  assign arr_src = arr_q[src_e];
  assign lat_v   = lat_q[v_q];
  assign sum     = {{(dlc_pkg::VAL_W - dlc_pkg::LAT_W + 1){1'b0}}, lat_v} + {1'b0, best_q};
  assign sat_sum = sum[dlc_pkg::VAL_W] ? {dlc_pkg::VAL_W{1'b1}} : sum[dlc_pkg::VAL_W-1:0];
  assign hit     = (dst_e == v_q) && mark_q[src_e];
  assign out_free = !out_v_q || res_ready_i;
  assign e_last  = {1'b0, e_q} == ec_q - dlc_pkg::ECNT_W'(1);
  assign v_last  = {1'b0, v_q} == nc_q - dlc_pkg::NCNT_W'(1);

  always_comb begin
    sts_o.action         = action_q;
    sts_o.from_bad       = {1'b0, from_q} >= nc_q;
    sts_o.to_bad         = {1'b0, to_q} >= nc_q;
    sts_o.self_loop      = from_q == to_q;
    sts_o.nodes_full     = nc_q == dlc_pkg::NCNT_W'(dlc_pkg::MAX_NODES);
    sts_o.edges_full     = ec_q == dlc_pkg::ECNT_W'(dlc_pkg::MAX_EDGES);
    sts_o.edges_none     = ec_q == '0;
    sts_o.e_last         = e_last;
    sts_o.v_last         = v_last;
    sts_o.mark_pass_last = pass_q == nc_q - dlc_pkg::NCNT_W'(1);
    sts_o.arr_pass_last  = pass_q == nc_q;
    sts_o.mark_v         = mark_q[v_q];
    sts_o.mark_to        = mark_q[to_q];
    sts_o.dly_hit        = hit;
    sts_o.is_target      = v_q == from_q;
    sts_o.cap_exceeded   = sat_sum > cap_q;
    sts_o.emit_ok        = !pend_v_q || out_free;
    sts_o.pend_v         = pend_v_q;
  end

  always_comb begin
    new_res      = '0;
    new_res.kind = dlc_pkg::K_ERROR;
    case (cmd_i.sel)
      dlc_pkg::EM_NODE: begin
        new_res.kind   = dlc_pkg::K_NODE;
        new_res.node_a = nc_q[dlc_pkg::NODE_W-1:0];
      end
      dlc_pkg::EM_ERR_UNKNOWN: new_res.value = dlc_pkg::ERR_UNKNOWN;
      dlc_pkg::EM_ERR_NODES:   new_res.value = dlc_pkg::ERR_NODES_FULL;
      dlc_pkg::EM_ERR_EDGES:   new_res.value = dlc_pkg::ERR_EDGES_FULL;
      dlc_pkg::EM_EDGE_REJ, dlc_pkg::EM_EDGE_ACC: begin
        new_res.kind   = dlc_pkg::K_EDGE;
        new_res.node_a = from_q;
        new_res.node_b = to_q;
        new_res.value  = dlc_pkg::VAL_W'(cmd_i.sel == dlc_pkg::EM_EDGE_ACC);
      end
      dlc_pkg::EM_DELAY: begin
        new_res.kind   = dlc_pkg::K_DELAY;
        new_res.node_a = src_e;
        new_res.node_b = v_q;
        new_res.value  = best_q - arr_src;
      end
      dlc_pkg::EM_DOMAIN: begin
        new_res.kind   = dlc_pkg::K_DOMAIN;
        new_res.node_a = v_q;
        new_res.value  = best_q;
      end
      dlc_pkg::EM_OVER: begin
        new_res.kind   = dlc_pkg::K_OVER;
        new_res.node_a = v_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    pend_v_d = pend_v_q;
    out_v_d  = out_v_q && !res_ready_i;
    if (cmd_i.emit) begin
      pend_v_d = 1'b1;
      if (pend_v_q) out_v_d = 1'b1;
    end else if (cmd_i.flush && pend_v_q && out_free) begin
      pend_v_d = 1'b0;
      out_v_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q     <= '0;
      ec_q     <= '0;
      e_q      <= '0;
      v_q      <= '0;
      pass_q   <= '0;
      mark_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cmd_i.node_wr) nc_q <= nc_q + dlc_pkg::NCNT_W'(1);
      if (cmd_i.edge_wr) ec_q <= ec_q + dlc_pkg::ECNT_W'(1);
      if (cmd_i.mark_init) begin
        mark_q <= dlc_pkg::MAX_NODES'(1) << from_q;
      end else if (cmd_i.mark_step && mark_q[dst_e]) begin
        mark_q[src_e] <= 1'b1;
      end
      if (cmd_i.e_clr) begin
        e_q <= '0;
      end else if (cmd_i.e_inc) begin
        e_q <= e_last ? '0 : e_q + dlc_pkg::EIDX_W'(1);
      end
      if (cmd_i.v_clr) begin
        v_q <= '0;
      end else if (cmd_i.v_inc) begin
        v_q <= v_last ? '0 : v_q + dlc_pkg::NODE_W'(1);
      end
      if (cmd_i.pass_clr) begin
        pass_q <= '0;
      end else if (cmd_i.pass_inc) begin
        pass_q <= pass_q + dlc_pkg::NCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      action_q <= dlc_pkg::action_e'(action_i);
      from_q   <= from_node_i;
      to_q     <= to_node_i;
      lat_in_q <= latency_i;
      cap_q    <= cap_i;
    end
    if (cmd_i.node_wr) lat_q[nc_q[dlc_pkg::NODE_W-1:0]] <= lat_in_q;
    if (cmd_i.edge_wr) begin
      src_q[ec_q[dlc_pkg::EIDX_W-1:0]] <= from_q;
      dst_q[ec_q[dlc_pkg::EIDX_W-1:0]] <= to_q;
    end
    if (cmd_i.arr_clr) begin
      for (int i = 0; i < dlc_pkg::MAX_NODES; i++) arr_q[i] <= '0;
    end else if (cmd_i.arr_wr) begin
      arr_q[v_q] <= sat_sum;
    end
    if (cmd_i.best_clr) begin
      best_q <= '0;
    end else if (cmd_i.best_acc && hit && (arr_src > best_q)) begin
      best_q <= arr_src;
    end
    if (cmd_i.emit) begin
      pend_q <= new_res;
      if (pend_v_q) out_q <= pend_q;
    end else if (cmd_i.flush && pend_v_q && out_free) begin
      out_q      <= pend_q;
      out_q.last <= 1'b1;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

/* hdl/dag_latency_compensation.sv */
// Add node ends at decode; add edge runs a mark sweep; compensate runs a mark sweep,
//   arrival sweeps and a result walk. Results can stall on m_axis_tready back-pressure.
// One item at a time: the next is accepted after the last result loads; the walks
//   go one edge or node per cycle when not stalled, through one shared compare/add unit.
// Reset: node and edge counts cleared; latency and edge tables hold no value until written.
`timescale 1ns / 1ps
`default_nettype none

module dag_latency_compensation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // from_node[3:0], to_node[7:4], latency[27:8],
                                          // cap[51:28], zero pad[55:52]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  // result out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // node_a[3:0], node_b[7:4], value[31:8]
  output logic [2:0]       m_axis_tuser,  // kind[2:0]
  output logic             m_axis_tlast   // last result of an item
);

  dlc_pkg::cmd_t cmd;
  dlc_pkg::sts_t sts;
  dlc_pkg::res_t res;

  // sequencer: decode, mark sweep, arrival sweeps, result walk
  dlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables, walk counters, one compare/add unit, held result plus output register
  dlc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (s_axis_tuser),
    .from_node_i (s_axis_tdata[3:0]),
    .to_node_i   (s_axis_tdata[7:4]),
    .latency_i   (s_axis_tdata[27:8]),
    .cap_i       (s_axis_tdata[51:28]),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // one result is held back so the final one can carry tlast
  assign m_axis_tdata = {res.value, res.node_b, res.node_a};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
